FILE: design/frtt_pkg.sv
// Shared types and constants for the feedback rtt congestion window tracker.
package frtt_pkg;

  localparam int RTT_WINDOW_DEPTH = 32;
  localparam int IDX_W  = (RTT_WINDOW_DEPTH > 1) ? $clog2(RTT_WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(RTT_WINDOW_DEPTH + 1);

  localparam int TIME_W = 40;
  localparam int RTT_W  = 16;
  localparam int BPS_W  = 31;
  localparam int WIN_W  = RTT_W + 1;
  localparam int PROD_W = BPS_W + WIN_W;
  localparam int CWND_W = 35;

  localparam logic [CWND_W-1:0] MIN_CWND_BYTES = CWND_W'(2 * 1500);
  localparam logic [CWND_W-1:0] CWND_MAX       = {CWND_W{1'b1}};
  localparam logic [RTT_W-1:0]  RTT_SAT        = {RTT_W{1'b1}};
  localparam logic [RTT_W-1:0]  QA_RESET       = RTT_W'(250);

  // x / 8000 == (x >> 6) / 125, taken 16 bits per step by reciprocal multiply
  localparam int DIV_SHIFT       = 6;
  localparam int DIV_DIVISOR     = 125;
  localparam int DIV_REM_W       = 7;
  localparam int DIV_CHUNK_W     = 16;
  localparam int DIV_STEPS       = 3;
  localparam int DIV_W           = DIV_STEPS * DIV_CHUNK_W;
  localparam int DIV_T_W         = DIV_REM_W + DIV_CHUNK_W;
  localparam int DIV_RECIP_SHIFT = 30;
  localparam int DIV_RECIP_W     = 24;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'(((1 << DIV_RECIP_SHIFT) + DIV_DIVISOR - 1) / DIV_DIVISOR);
  localparam int DIV_PROD_W      = DIV_T_W + DIV_RECIP_W;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_CWND_ENABLE     = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_ALLOWANCE = CFG_ADDR_W'(1);

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 56;

  localparam int IN_HAS_SEND  = 0;
  localparam int IN_HAS_RECV  = 1;
  localparam int IN_SEND_LSB  = 2;
  localparam int IN_FB_LSB    = IN_SEND_LSB + TIME_W;
  localparam int IN_EST_VALID = IN_FB_LSB + TIME_W;
  localparam int IN_BPS_LSB   = IN_EST_VALID + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_WALK,
    S_MULT,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic push;
    logic walk;
    logic mult;
    logic div_step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic item_end;
    logic pushing;
    logic cwnd_go;
    logic walk_done;
    logic div_last;
    logic out_free;
  } ctl_sts_t;

endpackage

FILE: design/feedback_rtt_cwnd_tracker_core.sv
// Top level of the feedback rtt window minimum and congestion window tracker.
//
// Input words carry one packet entry of a feedback report each; tlast marks the
// report's last entry and tuser low marks an empty-report marker, which ends a
// report by itself. Each accepted entry updates the report's largest rtt
// sample. At report end one output word follows with the congestion window
// and the window minimum rtt.
// At report end the sequencer pushes the report's sample, if any, walks the
// window memory one entry per cycle when a sample was pushed, multiplies and
// divides (16 quotient bits per cycle) when a window is computed, and loads
// the output register, which raises out_tvalid. New words are taken only
// while the sequencer idles, so a report's last entry holds the input until
// its result has been loaded into the output register.
// The output register lets the next report's entries be taken while a result
// waits; a stalled receiver holds the block at its next report end only.
// Reset (synchronous, rst_n low) empties the window, clears the report and
// sets cwnd_enable to 0 and queue_allowance_ms to 250. Configure while idle.
module feedback_rtt_cwnd_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [frtt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [frtt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // has_send_time, has_receive_time, packet send time ms, feedback_time_ms,
  // estimate_valid, estimate_bps, zero pad
  input  logic [frtt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  // entry_present
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cwnd_valid, cwnd_bytes, min_rtt_valid, min_rtt_ms, zero pad
  output logic [frtt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  frtt_pkg::ctl_cmd_t cmd;
  frtt_pkg::ctl_sts_t sts;

  frtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  frtt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: design/frtt_ctrl.sv
// Sequencer for report accumulation, window minimum walk and window division.
module frtt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  frtt_pkg::ctl_sts_t sts,
  output frtt_pkg::ctl_cmd_t cmd
);

  frtt_pkg::state_t state_r;
  frtt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frtt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frtt_pkg::S_IDLE: begin
        if (in_tvalid && sts.item_end) begin
          state_nxt = frtt_pkg::S_PUSH;
        end
      end
      frtt_pkg::S_PUSH: begin
        if (sts.pushing) begin
          state_nxt = frtt_pkg::S_WALK;
        end else if (sts.cwnd_go) begin
          state_nxt = frtt_pkg::S_MULT;
        end else begin
          state_nxt = frtt_pkg::S_EMIT;
        end
      end
      frtt_pkg::S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = sts.cwnd_go ? frtt_pkg::S_MULT : frtt_pkg::S_EMIT;
        end
      end
      frtt_pkg::S_MULT: begin
        state_nxt = frtt_pkg::S_DIV;
      end
      frtt_pkg::S_DIV: begin
        if (sts.div_last) begin
          state_nxt = frtt_pkg::S_EMIT;
        end
      end
      frtt_pkg::S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = frtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = frtt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      frtt_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
      end
      frtt_pkg::S_PUSH: begin
        cmd.push = 1'b1;
      end
      frtt_pkg::S_WALK: begin
        cmd.walk = 1'b1;
      end
      frtt_pkg::S_MULT: begin
        cmd.mult = 1'b1;
      end
      frtt_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      frtt_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_push_clears_report: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> !sts.pushing)
    else $error("report sample not cleared after push");

  a_end_item_starts_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_item && sts.item_end) |=> (state_r == frtt_pkg::S_PUSH && !in_tready))
    else $error("report end did not start push");
`endif

endmodule

FILE: design/frtt_dp.sv
// Datapath: report maximum, rtt window memory, minimum, multiply and divide.
module frtt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [frtt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [frtt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [frtt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [frtt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  frtt_pkg::ctl_cmd_t                  cmd,
  output frtt_pkg::ctl_sts_t                  sts
);

  logic [frtt_pkg::RTT_W-1:0] rtt_mem [frtt_pkg::RTT_WINDOW_DEPTH];
  logic [frtt_pkg::RTT_W-1:0] rd_data_r;

  logic                        cwnd_en_r, cwnd_en_nxt;
  logic [frtt_pkg::RTT_W-1:0]  qa_r, qa_nxt;
  logic [frtt_pkg::IDX_W-1:0]  wp_r, wp_nxt;
  logic [frtt_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [frtt_pkg::FILL_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [frtt_pkg::RTT_W-1:0]  rep_max_r, rep_max_nxt;
  logic                        rep_has_r, rep_has_nxt;
  logic [frtt_pkg::RTT_W-1:0]  min_hold_r, min_hold_nxt;
  logic                        est_valid_r, est_valid_nxt;
  logic [frtt_pkg::BPS_W-1:0]  est_bps_r, est_bps_nxt;
  logic                        cwnd_ok_r, cwnd_ok_nxt;
  logic [frtt_pkg::DIV_W-1:0]  dq_r, dq_nxt;
  logic [frtt_pkg::DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [frtt_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [frtt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [frtt_pkg::TIME_W:0]   rtt_diff;
  logic                        sample_ok;
  logic [frtt_pkg::RTT_W-1:0]  sample;
  logic [frtt_pkg::WIN_W-1:0]  win_ms;
  logic [frtt_pkg::PROD_W-1:0] prod;
  logic                        rd_en;
  logic [frtt_pkg::CWND_W-1:0] cwnd_sat;
  logic [frtt_pkg::DIV_T_W-1:0]    div_num;
  logic [frtt_pkg::DIV_PROD_W-1:0] div_prod;
  logic [frtt_pkg::DIV_CHUNK_W-1:0] div_qc;
  logic [frtt_pkg::DIV_T_W-1:0]    div_back;
  logic [frtt_pkg::DIV_W-1:0]  dq_step;
  logic [frtt_pkg::DIV_REM_W-1:0] rem_step;

  assign rtt_diff = {1'b0, in_tdata[frtt_pkg::IN_FB_LSB +: frtt_pkg::TIME_W]}
                  - {1'b0, in_tdata[frtt_pkg::IN_SEND_LSB +: frtt_pkg::TIME_W]};
  assign sample_ok = in_tuser && in_tdata[frtt_pkg::IN_HAS_SEND]
                  && in_tdata[frtt_pkg::IN_HAS_RECV] && !rtt_diff[frtt_pkg::TIME_W];
  assign sample = (|rtt_diff[frtt_pkg::TIME_W-1:frtt_pkg::RTT_W]) ? frtt_pkg::RTT_SAT
                : rtt_diff[frtt_pkg::RTT_W-1:0];

  assign win_ms = {1'b0, min_hold_r} + {1'b0, qa_r};
  assign prod   = est_bps_r * win_ms;

  assign rd_en = cmd.walk && (walk_cnt_r < fill_r);

  always_comb begin
    if (dq_r < frtt_pkg::DIV_W'(frtt_pkg::MIN_CWND_BYTES)) begin
      cwnd_sat = frtt_pkg::MIN_CWND_BYTES;
    end else if (dq_r > frtt_pkg::DIV_W'(frtt_pkg::CWND_MAX)) begin
      cwnd_sat = frtt_pkg::CWND_MAX;
    end else begin
      cwnd_sat = dq_r[frtt_pkg::CWND_W-1:0];
    end
  end

  // divide remainder and next 16 dividend bits by 125, shift quotient bits in
  assign div_num  = {rem_r, dq_r[frtt_pkg::DIV_W-1 -: frtt_pkg::DIV_CHUNK_W]};
  assign div_prod = frtt_pkg::DIV_PROD_W'(div_num)
                  * frtt_pkg::DIV_PROD_W'(frtt_pkg::DIV_RECIP);
  assign div_qc   = div_prod[frtt_pkg::DIV_RECIP_SHIFT +: frtt_pkg::DIV_CHUNK_W];
  assign div_back = frtt_pkg::DIV_T_W'(div_qc)
                  * frtt_pkg::DIV_T_W'(frtt_pkg::DIV_DIVISOR);
  assign rem_step = frtt_pkg::DIV_REM_W'(div_num - div_back);
  assign dq_step  = {dq_r[frtt_pkg::DIV_W-frtt_pkg::DIV_CHUNK_W-1:0], div_qc};

  always_comb begin
    cwnd_en_nxt    = cwnd_en_r;
    qa_nxt         = qa_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    walk_cnt_nxt   = walk_cnt_r;
    rep_max_nxt    = rep_max_r;
    rep_has_nxt    = rep_has_r;
    min_hold_nxt   = min_hold_r;
    est_valid_nxt  = est_valid_r;
    est_bps_nxt    = est_bps_r;
    cwnd_ok_nxt    = cwnd_ok_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      case (cfg_addr)
        frtt_pkg::CFG_CWND_ENABLE:     cwnd_en_nxt = cfg_wdata[0];
        frtt_pkg::CFG_QUEUE_ALLOWANCE: qa_nxt      = cfg_wdata[frtt_pkg::RTT_W-1:0];
        default: begin
          cwnd_en_nxt = cwnd_en_r;
        end
      endcase
    end

    if (cmd.load_item) begin
      est_valid_nxt = in_tdata[frtt_pkg::IN_EST_VALID];
      est_bps_nxt   = in_tdata[frtt_pkg::IN_BPS_LSB +: frtt_pkg::BPS_W];
      if (sample_ok) begin
        rep_has_nxt = 1'b1;
        if (!rep_has_r || sample > rep_max_r) begin
          rep_max_nxt = sample;
        end
      end
    end

    if (cmd.push) begin
      rep_has_nxt  = 1'b0;
      rep_max_nxt  = '0;
      cwnd_ok_nxt  = 1'b0;
      walk_cnt_nxt = '0;
      if (rep_has_r) begin
        wp_nxt = (wp_r == frtt_pkg::IDX_W'(frtt_pkg::RTT_WINDOW_DEPTH - 1))
               ? '0 : wp_r + 1'b1;
        if (fill_r != frtt_pkg::FILL_W'(frtt_pkg::RTT_WINDOW_DEPTH)) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
    end

    if (cmd.walk) begin
      walk_cnt_nxt = walk_cnt_r + 1'b1;
      if (walk_cnt_r == frtt_pkg::FILL_W'(1)) begin
        min_hold_nxt = rd_data_r;
      end else if (walk_cnt_r != '0 && rd_data_r < min_hold_r) begin
        min_hold_nxt = rd_data_r;
      end
    end

    if (cmd.mult) begin
      cwnd_ok_nxt = 1'b1;
      dq_nxt      = frtt_pkg::DIV_W'(prod[frtt_pkg::PROD_W-1:frtt_pkg::DIV_SHIFT]);
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      dq_nxt      = dq_step;
      rem_nxt     = rem_step;
      div_cnt_nxt = div_cnt_r + 1'b1;
    end

    if (cmd.emit) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = frtt_pkg::OUT_DATA_W'({
                         (fill_r != '0) ? min_hold_r : {frtt_pkg::RTT_W{1'b0}},
                         fill_r != '0,
                         cwnd_ok_r ? cwnd_sat : {frtt_pkg::CWND_W{1'b0}},
                         cwnd_ok_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwnd_en_r    <= 1'b0;
      qa_r         <= frtt_pkg::QA_RESET;
      wp_r         <= '0;
      fill_r       <= '0;
      walk_cnt_r   <= '0;
      rep_max_r    <= '0;
      rep_has_r    <= 1'b0;
      min_hold_r   <= '0;
      cwnd_ok_r    <= 1'b0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      cwnd_en_r    <= cwnd_en_nxt;
      qa_r         <= qa_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      walk_cnt_r   <= walk_cnt_nxt;
      rep_max_r    <= rep_max_nxt;
      rep_has_r    <= rep_has_nxt;
      min_hold_r   <= min_hold_nxt;
      cwnd_ok_r    <= cwnd_ok_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    est_valid_r <= est_valid_nxt;
    est_bps_r   <= est_bps_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && rep_has_r) begin
      rtt_mem[wp_r] <= rep_max_r;
    end
    if (rd_en) begin
      rd_data_r <= rtt_mem[walk_cnt_r[frtt_pkg::IDX_W-1:0]];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign sts.item_end  = !in_tuser || in_tlast;
  assign sts.pushing   = rep_has_r;
  assign sts.cwnd_go   = cwnd_en_r && est_valid_r && (fill_r != '0);
  assign sts.walk_done = (walk_cnt_r == fill_r);
  assign sts.div_last  = (div_cnt_r == frtt_pkg::DIV_CNT_W'(frtt_pkg::DIV_STEPS - 1));
  assign sts.out_free  = !out_tvalid_r || out_tready;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= frtt_pkg::FILL_W'(frtt_pkg::RTT_WINDOW_DEPTH))
    && (wp_r <= frtt_pkg::IDX_W'(frtt_pkg::RTT_WINDOW_DEPTH - 1)))
    else $error("window fill or write pointer out of range");

  a_emit_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("emitted word not presented");

  a_walk_only_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (fill_r != '0) && (walk_cnt_r <= fill_r))
    else $error("window walk past filled entries");
`endif

endmodule
